[src/lgsl_pkg.sv]
// shared types and constants for the led driver grayscale shift loader
`default_nettype none
package lgsl_pkg;

   localparam int CHIP_COUNT        = 4;
   localparam int CHANNELS_PER_CHIP = 16;
   localparam int GRAY_BITS         = 12;
   localparam int DOT_BITS_PER_CHIP = 16 * 6;

   localparam int REQ_W     = 3;
   localparam int CHAN_W    = 6;
   localparam int LEVEL_W   = 12;
   localparam int STORE_DEPTH = 64;
   localparam int CHIP_W    = 2;
   localparam int CHIDX_W   = 4;
   localparam int BIT_W     = 4;
   localparam int DOT_W     = 7;
   localparam int LATCH_W   = 4;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   // request codes
   localparam logic [REQ_W-1:0] REQ_WRITE = 3'd0;
   localparam logic [REQ_W-1:0] REQ_GRAY  = 3'd1;
   localparam logic [REQ_W-1:0] REQ_DOT   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SHIFT = 3'd3;
   localparam logic [REQ_W-1:0] REQ_END   = 3'd4;

   // everything of one result except the store lookup, plus how to finish it
   typedef struct packed {
      logic               shift_pulse;
      logic [LATCH_W-1:0] latch_mask;
      logic               blank_pulse;
      logic               program_level;
      logic               busy_res;
      logic               load_done;
      logic               rejected;
      logic               gray_sel;
      logic               fixed_bit;
      logic               hit;
      logic [BIT_W-1:0]   bit_sel;
   } stage_type;

   // store access issued by the control unit
   typedef struct packed {
      logic                          wr_en;
      logic [$clog2(STORE_DEPTH)-1:0] wr_addr;
      logic [LEVEL_W-1:0]            wr_data;
      logic                          rd_en;
      logic [$clog2(STORE_DEPTH)-1:0] rd_addr;
   } store_req_type;

endpackage
`default_nettype wire

[src/lgsl_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module lgsl_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[src/lgsl_ctrl.sv]
// load sequencer: mode, chip, channel and bit counters, store valid bits
`default_nettype none
module lgsl_ctrl import lgsl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [REQ_W-1:0]   req_code,
   input  wire logic [CHAN_W-1:0]  channel,
   input  wire logic [LEVEL_W-1:0] level,
   output store_req_type           store_req,
   output stage_type               stage
);

   typedef enum logic [1:0] {MODE_IDLE, MODE_GRAY, MODE_DOT} mode_type;

   mode_type               mode_ff, mode_in;
   logic                   await_ff, await_in;
   logic [CHIP_W-1:0]      chip_ff, chip_in;
   logic [CHIDX_W-1:0]     chan_ff, chan_in;
   logic [BIT_W-1:0]       bit_ff, bit_in;
   logic [DOT_W-1:0]       dot_ff, dot_in;
   logic                   prog_ff, prog_in;
   logic [STORE_DEPTH-1:0] valid_ff;
   logic                   busy;
   logic [DOT_W-1:0]       dot_inc;

   assign busy    = (mode_ff != MODE_IDLE);
   assign dot_inc = dot_ff + DOT_W'(1);

   always_comb begin
      mode_in  = mode_ff;
      await_in = await_ff;
      chip_in  = chip_ff;
      chan_in  = chan_ff;
      bit_in   = bit_ff;
      dot_in   = dot_ff;
      prog_in  = prog_ff;

      store_req.wr_en   = 1'b0;
      store_req.wr_addr = channel;
      store_req.wr_data = level;
      store_req.rd_en   = 1'b0;
      store_req.rd_addr = {chip_ff, chan_ff};

      stage             = '0;
      stage.bit_sel     = bit_ff;
      stage.hit         = valid_ff[{chip_ff, chan_ff}];

      case (req_code)
         REQ_WRITE: begin
            store_req.wr_en = accept;
         end
         REQ_GRAY, REQ_DOT: begin
            if (busy) begin
               stage.rejected = 1'b1;
            end else begin
               mode_in  = (req_code == REQ_GRAY) ? MODE_GRAY : MODE_DOT;
               prog_in  = (req_code == REQ_DOT);
               await_in = 1'b0;
               chip_in  = '0;
               chan_in  = CHIDX_W'(CHANNELS_PER_CHIP - 1);
               bit_in   = BIT_W'(GRAY_BITS - 1);
               dot_in   = '0;
            end
         end
         REQ_SHIFT: begin
            if (busy && !await_ff) begin
               stage.shift_pulse = 1'b1;
               if (mode_ff == MODE_GRAY) begin
                  stage.gray_sel  = 1'b1;
                  store_req.rd_en = accept;
                  if (bit_ff == '0) begin
                     bit_in = BIT_W'(GRAY_BITS - 1);
                     if (chan_ff == '0) begin
                        chan_in  = CHIDX_W'(CHANNELS_PER_CHIP - 1);
                        await_in = 1'b1;
                     end else begin
                        chan_in = chan_ff - CHIDX_W'(1);
                     end
                  end else begin
                     bit_in = bit_ff - BIT_W'(1);
                  end
               end else begin
                  stage.fixed_bit = 1'b1;
                  if (dot_inc >= DOT_W'(DOT_BITS_PER_CHIP)) begin
                     dot_in   = '0;
                     await_in = 1'b1;
                  end else begin
                     dot_in = dot_inc;
                  end
               end
            end
         end
         REQ_END: begin
            stage.blank_pulse = 1'b1;
            if (busy && await_ff) begin
               stage.latch_mask  = LATCH_W'(1) << chip_ff;
               stage.shift_pulse = 1'b1;
               await_in          = 1'b0;
               if (chip_ff == CHIP_W'(CHIP_COUNT - 1)) begin
                  stage.load_done = 1'b1;
                  mode_in         = MODE_IDLE;
                  chip_in         = '0;
               end else begin
                  chip_in = chip_ff + CHIP_W'(1);
               end
            end
         end
         default: begin
         end
      endcase

      stage.program_level = prog_in;
      stage.busy_res      = (mode_in != MODE_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         await_ff <= 1'b0;
         chip_ff  <= '0;
         chan_ff  <= CHIDX_W'(CHANNELS_PER_CHIP - 1);
         bit_ff   <= BIT_W'(GRAY_BITS - 1);
         dot_ff   <= '0;
         prog_ff  <= 1'b0;
         valid_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         await_ff <= await_in;
         chip_ff  <= chip_in;
         chan_ff  <= chan_in;
         bit_ff   <= bit_in;
         dot_ff   <= dot_in;
         prog_ff  <= prog_in;
         if (store_req.wr_en) begin
            valid_ff[channel] <= 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[src/led_driver_grayscale_shift_loader_core.sv]
// top level of the led driver grayscale shift loader
//
//   channel  dir  ports                         carries
//   req      in   req_tvalid/tready/tdata/tuser  one command beat
//   rsp      out  rsp_tvalid/tready/tdata        one status beat per command
//
// - one command beat accepted per cycle, sustained, with rsp_tready high
// - registered path: sequencer and store read, then result register
// - the store read port is the only memory access on the shift path
// - reset clears sequencer state and the 64 store valid bits at once
// - a stalled rsp holds its beat; req keeps flowing until both stages are full
`default_nettype none
module led_driver_grayscale_shift_loader_core import lgsl_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // tdata: channel[5:0], level[17:6], zero pad[23:18]
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: req_type[2:0]
   input  wire logic [REQ_W-1:0]       req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // tdata: serial_bit[0], shift_pulse[1], latch_mask[5:2], blank_pulse[6],
   //        program_level[7], busy_res[8], load_done[9], rejected[10], zero[15:11]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata
);

   logic                   accept;
   logic                   a_valid_ff;
   stage_type              a_ff;
   stage_type              stage;
   store_req_type          store_req;
   logic [LEVEL_W-1:0]     ram_q;
   logic                   b_valid_ff;
   logic [RSP_TDATA_W-1:0] b_data_ff, b_data_in;
   logic                   b_ready;
   logic                   serial_bit;

   // result register frees up when empty or being taken
   assign b_ready    = !b_valid_ff || rsp_tready;
   assign req_tready = !a_valid_ff || b_ready;
   assign accept     = req_tvalid && req_tready;

   lgsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_code  (req_tuser),
      .channel   (req_tdata[CHAN_W-1:0]),
      .level     (req_tdata[CHAN_W+LEVEL_W-1:CHAN_W]),
      .store_req (store_req),
      .stage     (stage)
   );

   // brightness store, read only on grayscale shift beats so a stall holds ram_q
   lgsl_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_req.wr_en),
      .wr_addr (store_req.wr_addr),
      .wr_data (store_req.wr_data),
      .rd_en   (store_req.rd_en),
      .rd_addr (store_req.rd_addr),
      .rd_data (ram_q)
   );

   // never-written entries read as zero
   assign serial_bit = a_ff.gray_sel ? (a_ff.hit & ram_q[a_ff.bit_sel]) : a_ff.fixed_bit;

   always_comb begin
      b_data_in         = '0;
      b_data_in[0]      = serial_bit;
      b_data_in[1]      = a_ff.shift_pulse;
      b_data_in[5:2]    = a_ff.latch_mask;
      b_data_in[6]      = a_ff.blank_pulse;
      b_data_in[7]      = a_ff.program_level;
      b_data_in[8]      = a_ff.busy_res;
      b_data_in[9]      = a_ff.load_done;
      b_data_in[10]     = a_ff.rejected;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff <= stage;
      end
      if (a_valid_ff && b_ready) begin
         b_data_ff <= b_data_in;
      end
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            a_valid_ff <= req_tvalid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = b_data_ff;

endmodule
`default_nettype wire

[src/lgsl_checker.sv]
// port-level checker for the loader, bound to the top level
`default_nettype none
module lgsl_checker import lgsl_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp beat right after reset");

   // stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // at most one chip latched, and a latch comes with blank and a clock
   a_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[5:2]) &&
                     (rsp_tdata[5:2] == '0 || (rsp_tdata[6] && rsp_tdata[1])))
      else $error("bad latch pulse");

   // load done only on a latch beat, and leaves the block idle
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[9] |-> rsp_tdata[5:2] != '0 && !rsp_tdata[8])
      else $error("load done without latch or still busy");

   // a rejected start means a load is still running
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[10] |-> rsp_tdata[8] && !rsp_tdata[1])
      else $error("rejected start while idle");

endmodule

bind led_driver_grayscale_shift_loader_core lgsl_checker u_lgsl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
